### design/lcfr_pkg.sv
package lcfr_pkg;

  localparam int ByteW = 8;
  localparam int LenW  = 16;
  localparam int ActW  = 2;
  localparam int StatW = 3;

  localparam logic [LenW-1:0] MaxLengthReset = '1;

  localparam logic [ActW-1:0] ACT_START   = 2'd0;
  localparam logic [ActW-1:0] ACT_BYTE    = 2'd1;
  localparam logic [ActW-1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_NO_MSG   = 3'd1;
  localparam logic [StatW-1:0] ST_TOO_LONG = 3'd2;
  localparam logic [StatW-1:0] ST_MISMATCH = 3'd3;
  localparam logic [StatW-1:0] ST_TIMEOUT  = 3'd4;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  byte_index;
    logic [StatW-1:0] status;
    logic [LenW-1:0]  frame_length;
  } result_t;

endpackage

### design/lcfr_core.sv
module lcfr_core import lcfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [ActW-1:0]  action,
  input  logic [ByteW-1:0] rx_byte,
  input  logic [LenW-1:0]  len_limit,
  output logic             res_valid,
  output result_t          res
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_CS_HI  = 3'd4,
    PH_CS_LO  = 3'd5
  } phase_t;

  phase_t           phase, phase_next;
  logic [LenW-1:0]  expected_length, expected_length_next;
  logic [LenW-1:0]  bytes_seen, bytes_seen_next;
  logic [LenW-1:0]  running_sum, running_sum_next;
  logic [ByteW-1:0] checksum_high, checksum_high_next;
  logic [LenW-1:0]  full_length;
  logic [LenW-1:0]  seen_inc;
  logic [LenW-1:0]  cs_received;
  logic             armed;

  assign armed       = (phase != PH_IDLE);
  assign full_length = {expected_length[LenW-1:ByteW], rx_byte};
  assign seen_inc    = bytes_seen + LenW'(1);
  assign cs_received = {checksum_high, rx_byte};

  always_comb begin
    phase_next           = phase;
    expected_length_next = expected_length;
    bytes_seen_next      = bytes_seen;
    running_sum_next     = running_sum;
    checksum_high_next   = checksum_high;
    res_valid            = 1'b0;
    res                  = '0;
    if (action == ACT_START) begin
      phase_next           = PH_LEN_HI;
      expected_length_next = '0;
      bytes_seen_next      = '0;
      running_sum_next     = '0;
      checksum_high_next   = '0;
    end else if (action == ACT_TIMEOUT) begin
      if (armed) begin
        phase_next = PH_IDLE;
        res_valid  = 1'b1;
        res.kind   = KIND_STATUS;
        res.status = ST_TIMEOUT;
        if (phase != PH_LEN_HI && phase != PH_LEN_LO) begin
          res.frame_length = expected_length;
        end
      end
    end else if (action == ACT_BYTE) begin
      case (phase)
        PH_LEN_HI: begin
          expected_length_next = {rx_byte, {ByteW{1'b0}}};
          phase_next           = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          expected_length_next = full_length;
          if (full_length == '0) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_NO_MSG;
          end else if (full_length > len_limit) begin
            phase_next       = PH_IDLE;
            res_valid        = 1'b1;
            res.kind         = KIND_STATUS;
            res.status       = ST_TOO_LONG;
            res.frame_length = full_length;
          end else begin
            bytes_seen_next  = '0;
            running_sum_next = '0;
            phase_next       = PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid        = 1'b1;
          res.kind         = KIND_BYTE;
          res.data_byte    = rx_byte;
          res.byte_index   = bytes_seen;
          running_sum_next = running_sum + LenW'(rx_byte);
          bytes_seen_next  = seen_inc;
          if (seen_inc == expected_length) begin
            phase_next = PH_CS_HI;
          end
        end
        PH_CS_HI: begin
          checksum_high_next = rx_byte;
          phase_next         = PH_CS_LO;
        end
        PH_CS_LO: begin
          phase_next       = PH_IDLE;
          res_valid        = 1'b1;
          res.kind         = KIND_STATUS;
          res.status       = (cs_received == running_sum) ? ST_OK : ST_MISMATCH;
          res.frame_length = expected_length;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      expected_length <= '0;
      bytes_seen      <= '0;
      running_sum     <= '0;
      checksum_high   <= '0;
    end else if (step) begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      bytes_seen      <= bytes_seen_next;
      running_sum     <= running_sum_next;
      checksum_high   <= checksum_high_next;
    end
  end

  a_data_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> expected_length != '0 && bytes_seen < expected_length)
    else $error("payload count outside frame length");

  a_byte_only_in_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_BYTE |-> phase == PH_DATA && action == ACT_BYTE)
    else $error("payload byte produced outside payload phase");

  a_status_ends_frame: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.kind == KIND_STATUS |=> phase == PH_IDLE)
    else $error("receiver still armed after status");

endmodule

### design/lcfr_out_reg.sv
module lcfr_out_reg import lcfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  input  logic    ready,
  output logic    valid,
  output result_t data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

### design/length_checksum_frame_receiver.sv
// Receives one length-prefixed frame from a byte stream: a start action arms
// the receiver, then it expects a 16-bit big-endian length, that many payload
// bytes and a 16-bit big-endian checksum (sum of payload bytes mod 65536).
// Every payload byte comes out with its index, and each frame not cut short by
// a new start ends with one status transfer (ok, no message, too long,
// checksum mismatch or timeout). Bytes and timeouts while idle produce nothing.
// One item is taken per cycle as long as results are taken: an input register
// feeds a combinational frame state update, whose result lands in an output
// register. The length limit may only be written while no item is in flight.
module length_checksum_frame_receiver import lcfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic [ActW-1:0]  action,
  input  logic [ByteW-1:0] rx_byte,
  output logic             result_valid,
  input  logic             result_ready,
  output logic             kind,
  output logic [ByteW-1:0] data_byte,
  output logic [LenW-1:0]  byte_index,
  output logic [StatW-1:0] status,
  output logic [LenW-1:0]  frame_length,
  input  logic             cfg_write,
  input  logic [LenW-1:0]  cfg_data
);

  logic             in_full;
  logic [ActW-1:0]  in_action;
  logic [ByteW-1:0] in_byte;
  logic [LenW-1:0]  len_limit;
  logic             advance;
  logic             res_valid;
  result_t          res;
  result_t          out_data;

  assign advance    = in_full && (!result_valid || result_ready);
  assign item_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_action <= action;
      in_byte   <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_limit <= MaxLengthReset;
    end else if (cfg_write) begin
      len_limit <= cfg_data;
    end
  end

  lcfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .action    (in_action),
    .rx_byte   (in_byte),
    .len_limit (len_limit),
    .res_valid (res_valid),
    .res       (res)
  );

  lcfr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .load_data (res),
    .ready     (result_ready),
    .valid     (result_valid),
    .data      (out_data)
  );

  assign kind         = out_data.kind;
  assign data_byte    = out_data.data_byte;
  assign byte_index   = out_data.byte_index;
  assign status       = out_data.status;
  assign frame_length = out_data.frame_length;

  a_byte_fields_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_BYTE |-> status == ST_OK && frame_length == '0)
    else $error("payload transfer carries status fields");

  a_status_fields_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_STATUS |-> data_byte == '0 && byte_index == '0)
    else $error("status transfer carries payload fields");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_data))
    else $error("pending result overwritten");

endmodule
